// ----- rtl/base64_stream_decoder_assert.svh -----
// Assertion macros used by the decoder top level.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define B64D_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define B64D_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/b64d_pkg.sv -----
package b64d_pkg;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_DIG_0 = 8'h30;
    localparam logic [7:0] CHAR_DIG_9 = 8'h39;

    localparam logic [5:0] LC_BASE    = 6'd26;
    localparam logic [5:0] DIG_BASE   = 6'd52;
    localparam logic [5:0] VAL_PLUS   = 6'd62;
    localparam logic [5:0] VAL_SLASH  = 6'd63;

    localparam logic [1:0] PADS_MAX   = 2'd3;
    localparam logic [1:0] LAST_CHAR  = 2'd3;

    typedef struct packed {
        logic [7:0] char_in;
        logic       first_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_run;
        logic       finished;
        logic       pad_error;
    } out_item_t;

    // One decoded quad handed from front to back.
    typedef struct packed {
        logic [23:0] quad;
        logic [1:0]  nbytes;
        logic        finished;
        logic        err;
    } job_t;

    typedef struct packed {
        logic       valid;
        logic       pad;
        logic [5:0] value;
    } sextet_t;

    typedef struct packed {
        logic full;
        logic empty;
    } jq_status_t;

    function automatic sextet_t b64_classify(input logic [7:0] c);
        sextet_t r;
        logic [7:0] d;
        r = '{valid: 1'b0, pad: 1'b0, value: 6'd0};
        d = 8'd0;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            d = c - CHAR_UC_A;
            r.valid = 1'b1;
            r.value = d[5:0];
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            d = c - CHAR_LC_A;
            r.valid = 1'b1;
            r.value = LC_BASE + d[5:0];
        end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
            d = c - CHAR_DIG_0;
            r.valid = 1'b1;
            r.value = DIG_BASE + d[5:0];
        end else if (c == CHAR_PLUS) begin
            r.valid = 1'b1;
            r.value = VAL_PLUS;
        end else if (c == CHAR_SLASH) begin
            r.valid = 1'b1;
            r.value = VAL_SLASH;
        end else if (c == CHAR_PAD) begin
            r.valid = 1'b1;
            r.pad   = 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/b64d_front.sv -----
module b64d_front
    import b64d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t din,
    input  logic     q_full,
    output logic     job_push,
    output job_t     job
);

    logic [23:0] quad_reg, quad_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  pads_reg, pads_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [23:0] quad_cur, quad_upd;
    logic [1:0]  cnt_cur, pads_cur, pads_upd;
    logic        halted_cur;
    sextet_t     cls;

    assign accept = push && !q_full;
    assign cls    = b64_classify(din.char_in);

    always_comb
    begin
        // New message drops any partial quad and the halt.
        quad_cur   = din.first_of_message ? 24'd0 : quad_reg;
        cnt_cur    = din.first_of_message ? 2'd0  : cnt_reg;
        pads_cur   = din.first_of_message ? 2'd0  : pads_reg;
        halted_cur = din.first_of_message ? 1'b0  : halted_reg;

        pads_upd = (cls.pad && pads_cur != PADS_MAX) ? pads_cur + 2'd1 : pads_cur;
        quad_upd = {quad_cur[17:0], (cls.pad ? 6'd0 : cls.value)};

        quad_next   = quad_reg;
        cnt_next    = cnt_reg;
        pads_next   = pads_reg;
        halted_next = halted_reg;
        job_push    = 1'b0;
        job.quad     = quad_upd;
        job.nbytes   = 2'd3 - pads_upd;
        job.finished = (pads_upd != 2'd0);
        job.err      = 1'b0;

        if (accept) begin
            quad_next   = quad_cur;
            cnt_next    = cnt_cur;
            pads_next   = pads_cur;
            halted_next = halted_cur;
            if (!halted_cur && cls.valid) begin
                if (cnt_cur != LAST_CHAR) begin
                    quad_next = quad_upd;
                    cnt_next  = cnt_cur + 2'd1;
                    pads_next = pads_upd;
                end else begin
                    job_push  = 1'b1;
                    quad_next = 24'd0;
                    cnt_next  = 2'd0;
                    pads_next = 2'd0;
                    if (pads_upd == PADS_MAX) begin
                        job.err      = 1'b1;
                        job.nbytes   = 2'd1;
                        job.finished = 1'b0;
                        halted_next  = 1'b1;
                    end else begin
                        halted_next = (pads_upd != 2'd0);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            quad_reg   <= 24'd0;
            cnt_reg    <= 2'd0;
            pads_reg   <= 2'd0;
            halted_reg <= 1'b0;
        end else begin
            quad_reg   <= quad_next;
            cnt_reg    <= cnt_next;
            pads_reg   <= pads_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ----- rtl/b64d_jobq.sv -----
module b64d_jobq
    import b64d_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  job_t       wr_job,
    input  logic       rd,
    output job_t       rd_job,
    output jq_status_t status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    job_t          slots_reg [DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign status.full  = (cnt_reg == CNT_FULL);
    assign status.empty = (cnt_reg == '0);
    assign do_wr  = wr && !status.full;
    assign do_rd  = rd && !status.empty;
    assign rd_job = slots_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_wr ? ((wp_reg == PTR_LAST) ? '0 : wp_reg + PW'(1)) : wp_reg;
        rp_next  = do_rd ? ((rp_reg == PTR_LAST) ? '0 : rp_reg + PW'(1)) : rp_reg;
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/b64d_back.sv -----
module b64d_back
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      q_job,
    input  logic      q_empty,
    output logic      q_pop,
    input  logic      pop,
    output logic      empty,
    output out_item_t dout
);

    job_t      job_reg, job_next;
    logic [1:0] idx_reg, idx_next;
    logic      busy_reg, busy_next;
    out_item_t out_reg, out_next;
    logic      oval_reg, oval_next;

    logic      out_free, is_last;
    logic [7:0] sel_byte;

    assign out_free = !oval_reg || pop;
    assign is_last  = (idx_reg == job_reg.nbytes - 2'd1);
    assign empty    = !oval_reg;
    assign dout     = out_reg;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = job_reg.quad[23:16];
            2'd1:    sel_byte = job_reg.quad[15:8];
            default: sel_byte = job_reg.quad[7:0];
        endcase
    end

    always_comb
    begin
        job_next  = job_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        out_next  = out_reg;
        oval_next = oval_reg && !pop;
        q_pop     = 1'b0;

        if (busy_reg && out_free) begin
            oval_next            = 1'b1;
            out_next.data_byte   = job_reg.err ? 8'd0 : sel_byte;
            out_next.last_of_run = is_last;
            out_next.finished    = is_last && job_reg.finished;
            out_next.pad_error   = job_reg.err;
            idx_next             = idx_reg + 2'd1;
            if (is_last)
                busy_next = 1'b0;
        end

        // Load the next quad as soon as the current one is drained.
        if ((!busy_reg || (out_free && is_last)) && !q_empty) begin
            q_pop     = 1'b1;
            job_next  = q_job;
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
            oval_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            oval_reg <= oval_next;
        end
    end

endmodule

// ----- rtl/base64_stream_decoder.sv -----
// channel  | handshake          | beat payload
// ---------+--------------------+-------------------------------------------
// input    | push / full        | din : char_in, first_of_message
// result   | pop / empty        | dout: data_byte, last_of_run, finished, pad_error
//
// One character per cycle is taken while the job queue has room; the front
// updates the quad in the accepting cycle and queues a job on every fourth
// alphabet or pad character while no pad has halted the message.
// The back drains one byte per cycle into the result register while that
// register is free; a first byte passes through the job queue, the back's job
// register and the result register.
// full rises only when JOB_DEPTH quads wait behind a stalled result side.
// Reset clears the quad, counters and halt flag and empties the job queue and the result register.
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int JOB_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  din,
    output logic      empty,
    input  logic      pop,
    output out_item_t dout
);

    logic       q_push, q_pop;
    job_t       q_wr_job, q_rd_job;
    jq_status_t q_stat;

    assign full = q_stat.full;

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .din      (din),
        .q_full   (q_stat.full),
        .job_push (q_push),
        .job      (q_wr_job)
    );

    b64d_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_push),
        .wr_job (q_wr_job),
        .rd     (q_pop),
        .rd_job (q_rd_job),
        .status (q_stat)
    );

    b64d_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_job   (q_rd_job),
        .q_empty (q_stat.empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .dout    (dout)
    );

    `B64D_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "job pushed into full queue")
    `B64D_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "job popped from empty queue")
    `B64D_ASSERT_IMP(a_end_is_last, !empty && (dout.finished || dout.pad_error),
        dout.last_of_run, "terminating beat without last_of_run")
    `B64D_ASSERT_NXT(a_job_drains, q_push && q_stat.empty, !q_stat.empty || q_pop,
        "queued job lost")

endmodule

// ----- test/tb_base64_stream_decoder.sv -----
module tb_base64_stream_decoder
    import b64d_pkg::*;
();

    localparam logic [6:0] SEXTET_PAD   = 7'd64;
    localparam logic [6:0] SEXTET_NONE  = 7'd65;
    localparam int         RANDOM_ITEMS = 120;
    localparam int         IDLE_LIMIT   = 1000;
    localparam int         DRAIN_CYCLES = 20;

    class b64_byte_board;
        logic [23:0] quad;
        logic [1:0]  nchars;
        logic [1:0]  npads;
        bit          halted;
        out_item_t   expected_bytes[$];
        int          failures;

        function new();
            quad     = '0;
            nchars   = '0;
            npads    = '0;
            halted   = 1'b0;
            failures = 0;
        endfunction

        // Six-bit value of a character; pad and junk get codes above 63.
        static function logic [6:0] sextet_value(logic [7:0] c);
            logic [7:0] d;
            if (c >= CHAR_UC_A && c <= CHAR_UC_Z)
                d = c - CHAR_UC_A;
            else if (c >= CHAR_LC_A && c <= CHAR_LC_Z)
                d = c - CHAR_LC_A + 8'(LC_BASE);
            else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9)
                d = c - CHAR_DIG_0 + 8'(DIG_BASE);
            else if (c == CHAR_PLUS)
                d = 8'(VAL_PLUS);
            else if (c == CHAR_SLASH)
                d = 8'(VAL_SLASH);
            else if (c == CHAR_PAD)
                d = 8'(SEXTET_PAD);
            else
                d = 8'(SEXTET_NONE);
            return d[6:0];
        endfunction

        // Returns 1 when the character entered the quad, 0 when ignored.
        function bit take_char(in_item_t item);
            logic [6:0]  v;
            logic [23:0] bits;
            int          nbytes;
            out_item_t   e;
            if (item.first_of_message) begin
                quad   = '0;
                nchars = '0;
                npads  = '0;
                halted = 1'b0;
            end
            if (halted)
                return 1'b0;
            v = sextet_value(item.char_in);
            if (v == SEXTET_NONE)
                return 1'b0;
            if (v == SEXTET_PAD) begin
                v = '0;
                if (npads != PADS_MAX)
                    npads++;
            end
            quad = {quad[17:0], v[5:0]};
            if (nchars != LAST_CHAR) begin
                nchars++;
                return 1'b1;
            end
            if (npads == PADS_MAX) begin
                e = '{data_byte: 8'h00, last_of_run: 1'b1, finished: 1'b0, pad_error: 1'b1};
                expected_bytes.push_back(e);
                halted = 1'b1;
            end else begin
                bits   = quad >> (8 * npads);
                nbytes = 3 - npads;
                for (int k = 0; k < nbytes; k++) begin
                    e.data_byte   = 8'(bits >> (8 * (nbytes - 1 - k)));
                    e.last_of_run = (k == nbytes - 1);
                    e.finished    = (k == nbytes - 1) && (npads != 0);
                    e.pad_error   = 1'b0;
                    expected_bytes.push_back(e);
                end
                if (npads != 0)
                    halted = 1'b1;
            end
            quad   = '0;
            nchars = '0;
            npads  = '0;
            return 1'b1;
        endfunction

        function void check_byte(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected beat: data_byte %h pad_error %b", got.data_byte,
                       got.pad_error);
                failures++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
                failures++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
                failures++;
            end
            if (got.finished !== want.finished) begin
                $error("finished: expected %b, got %b", want.finished, got.finished);
                failures++;
            end
            if (got.pad_error !== want.pad_error) begin
                $error("pad_error: expected %b, got %b", want.pad_error, got.pad_error);
                failures++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  din;
    logic      empty;
    logic      pop;
    out_item_t dout;

    b64_byte_board board = new();
    bit            steady;
    int            n_taken;
    int            idle_cycles;

    base64_stream_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (din),
        .empty (empty),
        .pop   (pop),
        .dout  (dout)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] alpha_char(int v);
        if (v < 26)
            return CHAR_UC_A + 8'(v);
        if (v < 52)
            return CHAR_LC_A + 8'(v - 26);
        if (v < 62)
            return CHAR_DIG_0 + 8'(v - 52);
        return (v == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    function automatic logic [7:0] rand_alpha();
        return alpha_char($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (b64_byte_board::sextet_value(c) != SEXTET_NONE);
        return c;
    endfunction

    task automatic send_char(logic [7:0] c, bit first);
        in_item_t item;
        int       gap;
        item = '{char_in: c, first_of_message: first};
        gap  = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        din  <= item;
        do
            @(posedge clk);
        while (full);
        void'(board.take_char(item));
        n_taken++;
    endtask

    task automatic send_text(string s, bit first);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], first && (i == 0));
    endtask

    // Hold the input side until every queued byte has drained.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_message();
        int  nquads;
        int  ending;
        int  npads;
        bit  first;
        bit  is_pad;
        first  = 1'b1;
        nquads = $urandom_range(0, 3);
        ending = $urandom_range(0, 5);
        steady = ($urandom_range(0, 3) == 0);
        for (int q = 0; q < nquads; q++) begin
            for (int i = 0; i < 4; i++) begin
                send_char(rand_alpha(), first);
                first = 1'b0;
                if ($urandom_range(0, 9) == 0)
                    send_char(junk_char(), 1'b0);
            end
        end
        if (ending == 0) begin
            // leave a partial quad for the next message to discard
            repeat ($urandom_range(0, 3)) begin
                send_char(rand_alpha(), first);
                first = 1'b0;
            end
        end else begin
            npads = ending - 1;
            for (int i = 0; i < 4; i++) begin
                if (ending == 5)
                    is_pad = ($urandom_range(0, 2) == 0);
                else
                    is_pad = (i >= 4 - npads);
                send_char(is_pad ? CHAR_PAD : rand_alpha(), first);
                first = 1'b0;
            end
            // characters after a halt are dropped
            if (ending >= 2 && $urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 3)) send_char(rand_alpha(), 1'b0);
        end
    endtask

    task automatic send_noise();
        steady = 1'b0;
        repeat ($urandom_range(1, 4))
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        bit pressed;
        rst_n   <= 1'b0;
        push    <= 1'b0;
        din     <= '0;
        steady  = 1'b0;
        pressed = 1'b0;
        n_taken = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("TWFu", 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("////", 1'b0);
        send_text("A", 1'b0);
        send_text("TWE=", 1'b1);
        send_text("Q", 1'b0);
        send_text("A===", 1'b1);
        send_text("A=BC", 1'b1);
        send_text("TQ==", 1'b1);
        wait_drained();

        while (n_taken < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_message();
            if (!pressed && n_taken >= RANDOM_ITEMS / 2) begin
                wait_drained();
                pressed = 1'b1;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("** base64_stream_decoder: PASSED **");
        else
            $display("** base64_stream_decoder: FAILED **");
        $finish;
    end

    initial
    begin
        int gap;
        pop <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            board.check_byte(dout);
        end
    end

    // End the run if no beat moves on either side for too long.
    initial
    begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** base64_stream_decoder: FAILED **");
                $finish;
            end
        end
    end

endmodule

// ----- base64_stream_decoder.f -----
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_jobq.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
test/tb_base64_stream_decoder.sv
